// ===== design/psd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Shared widths, types and the square root step for the 3-D point to segment
// distance block.
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int COORD_W     = 24;
   localparam int DIFF_W      = COORD_W + 1;       // w and v components
   localparam int PROD_W      = 2 * DIFF_W;        // products, norms, magnitudes
   localparam int CROSS_W     = PROD_W + 1;        // signed cross components
   localparam int HALF_W      = DIFF_W;            // split of a magnitude for squaring
   localparam int RAD_W       = 2 * PROD_W;        // |w x v|^2
   localparam int ROOT_W      = RAD_W / 2;
   localparam int REM_W       = ROOT_W + 3;
   localparam int LEN_W       = DIFF_W;
   localparam int DIST_W      = COORD_W + 1;
   localparam int FRONT_STEPS = PROD_W / 2;
   localparam int BACK_STEPS  = ROOT_W;
   localparam int DIV_STEPS   = DIST_W;
   localparam int FRONT_DEPTH = 7 + FRONT_STEPS + 1;
   localparam int BACK_DEPTH  = BACK_STEPS + 1 + DIV_STEPS + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int REQ_DATA_W  = 9 * COORD_W;
   localparam int RSP_DATA_W  = ((DIST_W + 7) / 8) * 8;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic              degenerate;
      logic [LEN_W-1:0]  len;
      logic [RAD_W-1:0]  rad;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // One restoring step of the bitwise square root: two radicand bits in,
   // one root bit out.
   function automatic sqrt_type sqrt_step(input sqrt_type s);
      sqrt_type         r;
      logic [REM_W-1:0] rem2;
      logic [REM_W-1:0] trial;
      rem2  = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
      trial = {1'b0, s.root, 2'b01};
      r.rad = {s.rad[RAD_W-3:0], 2'b00};
      if (rem2 >= trial) begin
         r.rem  = rem2 - trial;
         r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = rem2;
         r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ===== design/psd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_front
// Front pipeline: offsets, norms, cross product square, segment length and
// the degenerate decision. Pushes one classified item per transfer.
// ----------------------------------------------------------------------------
module psd_front import psd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [REQ_DATA_W-1:0] in_data,
   input  logic [COORD_W-1:0]    min_length,
   input  queue_status_type      status,
   output push_type              push
);

   function automatic logic signed [DIFF_W-1:0] coord(input logic [REQ_DATA_W-1:0] d,
                                                      input int k);
      logic [COORD_W-1:0] c;
      c = d[k*COORD_W +: COORD_W];
      return {c[COORD_W-1], c};
   endfunction

   logic                    adv;
   logic [FRONT_DEPTH-1:0]  vld_ff;
   logic [FRONT_DEPTH-1:0]  vld_in;

   logic signed [DIFF_W-1:0]  w_ff [3], w_in [3], v_ff [3], v_in [3];
   logic [PROD_W-1:0]         sqv_ff [3], sqv_in [3], sqw_ff [3], sqw_in [3];
   logic signed [PROD_W-1:0]  pr_ff [6], pr_in [6];
   logic signed [CROSS_W-1:0] c_ff [3], c_in [3], neg [3];
   logic [PROD_W-1:0]         mag_ff [3], mag_in [3];
   logic [PROD_W-1:0]         hh_ff [3], hh_in [3], hl_ff [3], hl_in [3];
   logic [PROD_W-1:0]         ll_ff [3], ll_in [3];
   logic [RAD_W-1:0]          csq_ff [3], csq_in [3];
   logic [RAD_W-1:0]          c2_ff, c2_in;
   logic [PROD_W-1:0]         nv2_ff [5], nv2_in [5], nw2_ff [5], nw2_in [5];
   sqrt_type                  sq_ff [FRONT_STEPS], sq_in [FRONT_STEPS];
   sqrt_type                  sq_init;
   logic [RAD_W-1:0]          sc2_ff [FRONT_STEPS], sc2_in [FRONT_STEPS];
   logic [PROD_W-1:0]         snw2_ff [FRONT_STEPS], snw2_in [FRONT_STEPS];
   item_type                  item_ff, item_in;
   logic [LEN_W-1:0]          len;

   assign adv      = !vld_ff[FRONT_DEPTH-1] || !status.full;
   assign in_ready = adv;
   assign vld_in   = {vld_ff[FRONT_DEPTH-2:0], in_valid};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         w_in[k]   = coord(in_data, k) - coord(in_data, k + 3);
         v_in[k]   = coord(in_data, k + 6) - coord(in_data, k + 3);
         sqv_in[k] = v_ff[k] * v_ff[k];
         sqw_in[k] = w_ff[k] * w_ff[k];
      end
      pr_in[0] = w_ff[1] * v_ff[2];
      pr_in[1] = w_ff[2] * v_ff[1];
      pr_in[2] = w_ff[2] * v_ff[0];
      pr_in[3] = w_ff[0] * v_ff[2];
      pr_in[4] = w_ff[0] * v_ff[1];
      pr_in[5] = w_ff[1] * v_ff[0];
      for (int k = 0; k < 3; k++) begin
         c_in[k]   = {pr_ff[2*k][PROD_W-1], pr_ff[2*k]}
                   - {pr_ff[2*k+1][PROD_W-1], pr_ff[2*k+1]};
         neg[k]    = -c_ff[k];
         mag_in[k] = c_ff[k][CROSS_W-1] ? neg[k][PROD_W-1:0] : c_ff[k][PROD_W-1:0];
         hh_in[k]  = mag_ff[k][PROD_W-1 -: HALF_W] * mag_ff[k][PROD_W-1 -: HALF_W];
         hl_in[k]  = mag_ff[k][PROD_W-1 -: HALF_W] * mag_ff[k][HALF_W-1:0];
         ll_in[k]  = mag_ff[k][HALF_W-1:0] * mag_ff[k][HALF_W-1:0];
         csq_in[k] = {hh_ff[k], {(2*HALF_W){1'b0}}}
                   + RAD_W'({hl_ff[k], {(HALF_W+1){1'b0}}})
                   + RAD_W'(ll_ff[k]);
      end
      c2_in = csq_ff[0] + csq_ff[1] + csq_ff[2];

      // norms travel alongside the cross product stages
      nv2_in[0] = sqv_ff[0] + sqv_ff[1] + sqv_ff[2];
      nw2_in[0] = sqw_ff[0] + sqw_ff[1] + sqw_ff[2];
      for (int k = 1; k < 5; k++) begin
         nv2_in[k] = nv2_ff[k-1];
         nw2_in[k] = nw2_ff[k-1];
      end

      // length of v: |v|^2 sits in the upper half of the radicand
      sq_init.rad  = {nv2_ff[4], {PROD_W{1'b0}}};
      sq_init.rem  = '0;
      sq_init.root = '0;
      sq_in[0]   = sqrt_step(sq_init);
      sc2_in[0]  = c2_ff;
      snw2_in[0] = nw2_ff[4];
      for (int k = 1; k < FRONT_STEPS; k++) begin
         sq_in[k]   = sqrt_step(sq_ff[k-1]);
         sc2_in[k]  = sc2_ff[k-1];
         snw2_in[k] = snw2_ff[k-1];
      end

      len                = sq_ff[FRONT_STEPS-1].root[LEN_W-1:0];
      item_in.len        = len;
      item_in.degenerate = (len == '0) || (len < {1'b0, min_length});
      item_in.rad        = item_in.degenerate ? RAD_W'(snw2_ff[FRONT_STEPS-1])
                                              : sc2_ff[FRONT_STEPS-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff    <= w_in;
         v_ff    <= v_in;
         sqv_ff  <= sqv_in;
         sqw_ff  <= sqw_in;
         pr_ff   <= pr_in;
         c_ff    <= c_in;
         mag_ff  <= mag_in;
         hh_ff   <= hh_in;
         hl_ff   <= hl_in;
         ll_ff   <= ll_in;
         csq_ff  <= csq_in;
         c2_ff   <= c2_in;
         nv2_ff  <= nv2_in;
         nw2_ff  <= nw2_in;
         sq_ff   <= sq_in;
         sc2_ff  <= sc2_in;
         snw2_ff <= snw2_in;
         item_ff <= item_in;
      end
   end

   assign push.valid = vld_ff[FRONT_DEPTH-1] && !status.full;
   assign push.item  = item_ff;

endmodule

// ===== design/psd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_queue
// Four entry queue of classified items between front and back pipelines.
// ----------------------------------------------------------------------------
module psd_queue import psd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic             pop,
   output item_type         head,
   output queue_status_type status
);

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !status.full) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty) else $error("pop from empty queue");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push.valid && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not grow");
   a_count_down: assert property (@(posedge clock) disable iff (reset)
      pop && !push.valid |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not shrink");

endmodule

// ===== design/psd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_back
// Back pipeline: shared square root, divide by segment length, saturation
// and the output register.
// ----------------------------------------------------------------------------
module psd_back import psd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  item_type          head,
   input  queue_status_type  status,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DIST_W-1:0] out_distance,
   output logic              out_degenerate
);

   typedef struct packed {
      logic [LEN_W-1:0]  r;
      logic [DIST_W-1:0] s;
      logic [DIST_W-1:0] q;
      logic [LEN_W-1:0]  len;
      logic              degenerate;
      logic              sat;
      logic [DIST_W-1:0] direct;
   } div_type;

   function automatic div_type div_step(input div_type d);
      div_type         n;
      logic [LEN_W:0]  r2;
      logic [LEN_W:0]  diff;
      logic            ge;
      n    = d;
      r2   = {d.r, d.s[DIST_W-1]};
      diff = r2 - {1'b0, d.len};
      ge   = (r2 >= {1'b0, d.len});
      n.r  = ge ? diff[LEN_W-1:0] : r2[LEN_W-1:0];
      n.s  = {d.s[DIST_W-2:0], 1'b0};
      n.q  = {d.q[DIST_W-2:0], ge};
      return n;
   endfunction

   logic                  adv;
   logic [BACK_DEPTH-1:0] vld_ff, vld_in;
   sqrt_type              st_ff [BACK_STEPS], st_in [BACK_STEPS];
   sqrt_type              st_init;
   logic                  sdeg_ff [BACK_STEPS], sdeg_in [BACK_STEPS];
   logic [LEN_W-1:0]      slen_ff [BACK_STEPS], slen_in [BACK_STEPS];
   div_type               dv_ff [DIV_STEPS+1], dv_in [DIV_STEPS+1];
   logic [ROOT_W-1:0]     root;
   logic [DIST_W-1:0]     dist_ff, dist_in;
   logic                  deg_ff;

   assign adv    = !vld_ff[BACK_DEPTH-1] || out_ready;
   assign pop    = adv && !status.empty;
   assign vld_in = {vld_ff[BACK_DEPTH-2:0], !status.empty};

   always_comb begin
      st_init.rad  = head.rad;
      st_init.rem  = '0;
      st_init.root = '0;
      st_in[0]   = sqrt_step(st_init);
      sdeg_in[0] = head.degenerate;
      slen_in[0] = head.len;
      for (int k = 1; k < BACK_STEPS; k++) begin
         st_in[k]   = sqrt_step(st_ff[k-1]);
         sdeg_in[k] = sdeg_ff[k-1];
         slen_in[k] = slen_ff[k-1];
      end

      root                = st_ff[BACK_STEPS-1].root;
      dv_in[0].r          = root[ROOT_W-1 -: LEN_W];
      dv_in[0].s          = root[DIST_W-1:0];
      dv_in[0].q          = '0;
      dv_in[0].len        = slen_ff[BACK_STEPS-1];
      dv_in[0].degenerate = sdeg_ff[BACK_STEPS-1];
      dv_in[0].sat        = (root[ROOT_W-1 -: LEN_W] >= slen_ff[BACK_STEPS-1]);
      dv_in[0].direct     = root[DIST_W-1:0];
      for (int k = 1; k <= DIV_STEPS; k++) begin
         dv_in[k] = div_step(dv_ff[k-1]);
      end

      if (dv_ff[DIV_STEPS].degenerate) begin
         dist_in = dv_ff[DIV_STEPS].direct;
      end else if (dv_ff[DIV_STEPS].sat) begin
         dist_in = '1;
      end else begin
         dist_in = dv_ff[DIV_STEPS].q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff   <= st_in;
         sdeg_ff <= sdeg_in;
         slen_ff <= slen_in;
         dv_ff   <= dv_in;
         dist_ff <= dist_in;
         deg_ff  <= dv_ff[DIV_STEPS].degenerate;
      end
   end

   assign out_valid      = vld_ff[BACK_DEPTH-1];
   assign out_distance   = dist_ff;
   assign out_degenerate = deg_ff;

endmodule

// ===== design/point_segment_distance_3d.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance_3d
// Distance from a 3-D point to the line through a segment, Q16.8 in, Q17.8
// out, with a degenerate-segment fallback to the start point.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | transfer when
//  req_    | in  | tdata: point, start, end (x,y,z each)    | tvalid & tready
//  rsp_    | out | tdata: distance  tuser: degenerate       | tvalid & tready
//  csr_    | in  | wdata: min_length                        | valid & ready
//
//  Throughput: one item per cycle, sustained while rsp_tready stays high.
//  Items pass the front, the queue and the back; pipeline depth is set
//  by the bit-per-stage square roots (25 and 50 stages) and 25 divide stages.
//  Reset (synchronous) empties both pipelines and the queue; min_length = 1.
//  rsp_tready low freezes the back; the 4-entry queue then fills before
//  req_tready drops. csr_ready is always high.
// ----------------------------------------------------------------------------
module point_segment_distance_3d import psd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // point_x, point_y, point_z, start_x, start_y, start_z, end_x, end_y, end_z
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // distance, zero fill above
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // degenerate
   output logic [0:0]            rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [COORD_W-1:0]    csr_wdata
);

   logic [COORD_W-1:0] min_length_ff;
   push_type           push;
   item_type           head;
   queue_status_type   status;
   logic               pop;
   logic [DIST_W-1:0]  distance;
   logic               degenerate;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= COORD_W'(1);
      end else if (csr_valid && csr_ready) begin
         min_length_ff <= csr_wdata;
      end
   end

   // front: offsets, products, |v| and the degenerate choice of radicand
   psd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_data    (req_tdata),
      .min_length (min_length_ff),
      .status     (status),
      .push       (push)
   );

   psd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (status)
   );

   // back: shared root of |w|^2 or |w x v|^2, divided by length if not degenerate
   psd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .status         (status),
      .pop            (pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_distance   (distance),
      .out_degenerate (degenerate)
   );

   assign rsp_tdata    = RSP_DATA_W'(distance);
   assign rsp_tuser[0] = degenerate;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for point_segment_distance_3d: a local fixed point model
// predicts distance and degenerate flag per request; random valid/ready gaps,
// one long response hold-off, and min_length swept between idle phases.
// ----------------------------------------------------------------------------
module tb;
   import psd_pkg::*;

   typedef struct {
      logic signed [COORD_W-1:0] p[3];
      logic signed [COORD_W-1:0] s[3];
      logic signed [COORD_W-1:0] e[3];
   } query_type;

   typedef struct {
      logic [DIST_W-1:0] distance;
      logic              degen;
   } answer_type;

   localparam int LATENCY   = 120;
   localparam int CYCLE_CAP = 400000;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [COORD_W-1:0]    csr_wdata = '0;

   query_type  pending_q[$];
   answer_type answer_q[$];
   logic [COORD_W-1:0] min_len = COORD_W'(1);
   int  errors = 0;
   int  cycles = 0;
   bit  quiet = 0;        // no idling in the last part
   bit  hold_rsp = 0;     // long response hold-off request
   int  send_gap = 0;
   int  recv_gap = 0;
   int  hold_cnt = 0;
   // accept flag from the last rising edge
   logic req_tready_seen = 0;

   point_segment_distance_3d u_top (.*);

   always #5 clock = ~clock;

   // exact floor square root, bit by bit
   function automatic logic [199:0] isqrt(input logic [199:0] n);
      logic [199:0] root, bitv;
      root = '0;
      bitv = 200'd1 << 198;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n    = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic answer_type predict_distance(input query_type q);
      answer_type a;
      logic signed [127:0] w[3], v[3], c[3];
      logic [199:0] lsq, wsq, csq, len, quo;
      for (int i = 0; i < 3; i++) begin
         w[i] = 128'(q.p[i]) - 128'(q.s[i]);
         v[i] = 128'(q.e[i]) - 128'(q.s[i]);
      end
      lsq = 200'(v[0]*v[0]) + 200'(v[1]*v[1]) + 200'(v[2]*v[2]);
      len = isqrt(lsq);
      if (len == 0 || len < min_len) begin
         wsq     = 200'(w[0]*w[0]) + 200'(w[1]*w[1]) + 200'(w[2]*w[2]);
         quo     = isqrt(wsq);
         a.degen = 1'b1;
      end else begin
         c[0] = w[1]*v[2] - w[2]*v[1];
         c[1] = w[2]*v[0] - w[0]*v[2];
         c[2] = w[0]*v[1] - w[1]*v[0];
         csq  = '0;
         for (int i = 0; i < 3; i++) begin
            // |c| < 2^52, square fits in 128 bits unsigned
            if (c[i] < 0) c[i] = -c[i];
            csq = csq + 200'(c[i][103:0] * c[i][103:0]);
         end
         quo     = isqrt(csq) / len;
         a.degen = 1'b0;
      end
      a.distance = (quo > {DIST_W{1'b1}}) ? {DIST_W{1'b1}} : quo[DIST_W-1:0];
      return a;
   endfunction

   // driver: next pending item on the falling edge, random bursts of idling
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready_seen) begin
            if (send_gap > 0) begin
               send_gap   <= send_gap - 1;
               req_tvalid <= 0;
            end else if (pending_q.size() > 0) begin
               query_type q;
               q = pending_q.pop_front();
               answer_q.push_back(predict_distance(q));
               req_tdata  <= {q.e[2], q.e[1], q.e[0], q.s[2], q.s[1], q.s[0],
                              q.p[2], q.p[1], q.p[0]};
               req_tvalid <= 1;
               if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 15);
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   always @(posedge clock) req_tready_seen <= req_tvalid && req_tready;

   // receiver ready: random bursts, plus the long hold-off counted here
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_rsp && hold_cnt == 0) begin
            hold_cnt   <= 400;
            rsp_tready <= 0;
         end else if (hold_cnt > 1) begin
            hold_cnt   <= hold_cnt - 1;
            rsp_tready <= 0;
         end else if (hold_cnt == 1) begin
            hold_cnt   <= -1;
            rsp_tready <= 1;
         end else if (recv_gap > 0) begin
            recv_gap   <= recv_gap - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
            if (!quiet && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 15);
         end
      end
   end

   // monitor: compare each response transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (answer_q.size() == 0) begin
            $error("unexpected response distance=%0d", rsp_tdata[DIST_W-1:0]);
            errors++;
         end else begin
            answer_type a;
            a = answer_q.pop_front();
            if (rsp_tdata[DIST_W-1:0] !== a.distance) begin
               $error("distance expected %0d actual %0d", a.distance,
                      rsp_tdata[DIST_W-1:0]);
               errors++;
            end
            if (rsp_tuser[0] !== a.degen) begin
               $error("degenerate expected %0d actual %0d", a.degen, rsp_tuser[0]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_CAP) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic signed [COORD_W-1:0] rnd_coord(input int mode);
      case (mode)
         0:       return COORD_W'($urandom);
         1:       return COORD_W'($urandom_range(0, 511)) - COORD_W'(256);
         2:       return $urandom_range(0, 1) ? {1'b0, {(COORD_W-1){1'b1}}}
                                              : {1'b1, {(COORD_W-1){1'b0}}};
         default: return COORD_W'($urandom_range(0, 65535)) - COORD_W'(32768);
      endcase
   endfunction

   task automatic add_query(input int a, b, c, d, f, g, h, i, j);
      query_type q;
      q.p = '{COORD_W'(a), COORD_W'(b), COORD_W'(c)};
      q.s = '{COORD_W'(d), COORD_W'(f), COORD_W'(g)};
      q.e = '{COORD_W'(h), COORD_W'(i), COORD_W'(j)};
      pending_q.push_back(q);
   endtask

   task automatic add_random(input int n);
      query_type q;
      int m;
      repeat (n) begin
         m = $urandom_range(0, 3);
         for (int k = 0; k < 3; k++) begin
            q.p[k] = rnd_coord(m);
            q.s[k] = rnd_coord(m);
            q.e[k] = rnd_coord(m);
         end
         // short segments now and then, to hit the tolerance path
         if ($urandom_range(0, 5) == 0)
            for (int k = 0; k < 3; k++)
               q.e[k] = q.s[k] + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
         pending_q.push_back(q);
      end
   endtask

   // wait until all is sent and answered, then for the pipeline to drain
   task automatic drain();
      while (pending_q.size() != 0 || req_tvalid || answer_q.size() != 0)
         @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_min_len(input logic [COORD_W-1:0] val);
      @(negedge clock);
      csr_wdata <= val;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      min_len = val;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   localparam int MAXC = 8388607;
   localparam int MINC = -8388608;

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: zero segment, extremes, tiny segments, overflow of the divide
      add_query(0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_query(MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MINC, MINC);
      add_query(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC);
      add_query(MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC);
      add_query(MINC, MAXC, 0, MAXC, MINC, 0, MINC, MAXC, 1);
      add_query(MAXC, MAXC, MINC, 0, 0, 0, 1, 0, 0);
      add_query(MINC, MAXC, MAXC, 0, 0, 0, 0, 1, 0);
      add_query(256, 256, 0, 0, 0, 0, 512, 0, 0);
      add_query(-1, -1, -1, 1, 1, 1, 2, 2, 2);
      add_query(100, 200, 300, 0, 0, 0, 0, 0, 1);
      add_query(MAXC, 0, 0, MINC, 0, 0, MAXC, 0, 0);
      add_query(0, MAXC, 0, 0, MINC, 0, 0, MAXC, 0);
      add_query(5, 5, 5, 5, 5, 5, 5, 5, 5);
      drain();

      write_min_len('0);
      add_query(3, 4, 0, 0, 0, 0, 0, 0, 0);
      add_query(MAXC, MAXC, MAXC, 0, 0, 0, 1, 1, 0);
      add_random(80);
      drain();

      write_min_len({COORD_W{1'b1}});
      add_query(1, 2, 3, MINC, MINC, MINC, MAXC, MAXC, MAXC);
      add_random(60);
      drain();

      write_min_len(24'd300);
      add_random(100);
      // long stall on responses while requests keep coming
      hold_rsp = 1;
      add_random(100);
      drain();
      hold_rsp = 0;

      write_min_len(24'd1);
      quiet = 1;
      add_random(100);
      drain();

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
